[rtl/gbn_pkg.sv]
// shared types, constants and helpers for the go-back-n sender
package gbn_pkg;

    localparam int SEQ_MODULUS = 10;
    localparam int WINDOW      = 5;
    localparam int SEQ_W       = 4;
    localparam int IDX_W       = 16;
    localparam int ACK_W       = 8;
    localparam int PS_W        = 17;
    localparam int TMO_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;
    localparam int Q_CW        = 3;

    localparam logic [7:0] CODE_ACCEPT = 8'd200;
    localparam logic [7:0] CODE_END    = 8'd211;

    localparam logic [1:0] CMD_EMPTY   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 8'd10;

    localparam int          RECIP_SH = 16;
    localparam logic [16:0] RECIP    = 17'((2 ** RECIP_SH) / SEQ_MODULUS);

    typedef enum logic [2:0] {
        PH_ANNOUNCE = 3'd0,
        PH_ACCEPT   = 3'd1,
        PH_SEND     = 3'd2,
        PH_ENDACK   = 3'd3,
        PH_STOP     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        K_READY   = 3'd0,
        K_DATA    = 3'd1,
        K_END     = 3'd2,
        K_DONE    = 3'd3,
        K_TIMEOUT = 3'd4,
        K_BADCODE = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SEQ_W-1:0]   seq;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // x mod SEQ_MODULUS for x up to 256, reciprocal multiply plus one correction
    function automatic logic [SEQ_W-1:0] seq_mod(input logic [8:0] x);
        logic [25:0] prod;
        logic [9:0]  q;
        logic [13:0] r;
        prod = 26'(x) * 26'(RECIP);
        q    = prod[25:16];
        r    = 14'(x) - 14'(q) * 14'(SEQ_MODULUS);
        if (r >= 14'(SEQ_MODULUS)) begin
            r = r - 14'(SEQ_MODULUS);
        end
        return r[SEQ_W-1:0];
    endfunction

endpackage

[rtl/gbn_ifs.sv]
// valid/ready channel interfaces for polls, results and register writes
interface gbn_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    modport source (output valid, cmd, rx_byte, input ready);
    modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface gbn_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  seq_out;
    logic [15:0] packet_index;
    logic        last;
    modport source (output valid, kind, seq_out, packet_index, last, input ready);
    modport sink   (input valid, kind, seq_out, packet_index, last, output ready);
endinterface

interface gbn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/gbn_core.sv]
// protocol state, config registers and per-poll result generation
module gbn_core
    import gbn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [IDX_W-1:0]     i_cfg_data,
    input  logic                 i_room,
    output t_push                o_push
);

    logic                 r_in_valid;
    logic [1:0]           r_cmd;
    logic [7:0]           r_rx;
    logic [IDX_W-1:0]     r_total;
    logic [TMO_W-1:0]     r_timeout;
    t_phase               r_phase, n_phase;
    logic [SEQ_W-1:0]     r_seq, n_seq;
    logic [ACK_W-1:0]     r_ack, n_ack;
    logic [PS_W-1:0]      r_ps, n_ps;
    logic [TMO_W-1:0]     r_ep, n_ep;
    logic                 go;
    logic [TMO_W-1:0]     ep_inc;
    logic                 tmo_hit;
    logic [SEQ_W-1:0]     s1;
    logic [PS_W-1:0]      p1;
    logic [PS_W-1:0]      end_ps;
    t_result              res [2];
    logic [1:0]           nres;

    function automatic logic signed [9:0] win_len(input logic [SEQ_W-1:0] s,
                                                  input logic [ACK_W-1:0] a,
                                                  input logic incl);
        logic signed [9:0] sv;
        logic signed [9:0] av;
        sv = $signed({6'b0, s});
        av = $signed({2'b0, a});
        if ((sv > av) || (incl && (sv == av))) begin
            return sv - av;
        end
        return sv + 10'(SEQ_MODULUS) - av;
    endfunction

    function automatic t_result mk(input t_kind k, input logic [SEQ_W-1:0] s,
                                   input logic [IDX_W-1:0] i);
        t_result r;
        r.kind = k;
        r.seq  = s;
        r.idx  = i;
        r.last = 1'b0;
        return r;
    endfunction

    assign go         = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || go;
    assign ep_inc     = r_ep + 8'd1;
    assign tmo_hit    = (ep_inc == r_timeout);
    assign end_ps     = PS_W'(r_total) + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_total    <= '0;
            r_timeout  <= TIMEOUT_RESET;
            r_phase    <= PH_ANNOUNCE;
            r_seq      <= '0;
            r_ack      <= '0;
            r_ps       <= '0;
            r_ep       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_TOTAL) begin
                    r_total <= i_cfg_data;
                end else if (i_cfg_index == CFG_TIMEOUT) begin
                    r_timeout <= i_cfg_data[TMO_W-1:0];
                end
            end
            r_phase <= n_phase;
            r_seq   <= n_seq;
            r_ack   <= n_ack;
            r_ps    <= n_ps;
            r_ep    <= n_ep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= i_cmd;
            r_rx  <= i_rx_byte;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        n_ack   = r_ack;
        n_ps    = r_ps;
        n_ep    = r_ep;
        res[0]  = mk(K_READY, '0, '0);
        res[1]  = mk(K_READY, '0, '0);
        nres    = 2'd0;
        s1      = r_seq;
        p1      = r_ps;
        if (go) begin
            if (r_cmd == CMD_RESTART) begin
                n_phase = PH_ANNOUNCE;
                n_seq   = '0;
                n_ack   = '0;
                n_ps    = '0;
                n_ep    = '0;
            end else if (r_cmd != CMD_UNUSED) begin
                unique case (r_phase)
                    PH_ANNOUNCE: begin
                        res[0]  = mk(K_READY, '0, '0);
                        nres    = 2'd1;
                        n_phase = PH_ACCEPT;
                        n_ep    = '0;
                    end
                    PH_ACCEPT: begin
                        if (r_cmd == CMD_EMPTY) begin
                            n_ep = ep_inc;
                            if (tmo_hit) begin
                                n_ep    = '0;
                                res[0]  = mk(K_TIMEOUT, '0, '0);
                                nres    = 2'd1;
                                n_phase = PH_STOP;
                            end
                        end else if (r_rx == CODE_ACCEPT) begin
                            n_seq   = SEQ_W'(1);
                            n_ack   = '0;
                            n_ps    = '0;
                            n_ep    = '0;
                            n_phase = PH_SEND;
                        end else begin
                            res[0]  = mk(K_BADCODE, '0, '0);
                            nres    = 2'd1;
                            n_phase = PH_STOP;
                        end
                    end
                    PH_SEND: begin
                        if ((win_len(r_seq, r_ack, 1'b0) < 10'(WINDOW))
                            && (r_ps <= PS_W'(r_total))) begin
                            res[0] = mk(K_DATA, r_seq, r_ps[IDX_W-1:0]);
                            nres   = 2'd1;
                            s1     = (r_seq == SEQ_W'(SEQ_MODULUS - 1)) ? '0
                                                                         : r_seq + 4'd1;
                            p1     = r_ps + 17'd1;
                        end
                        n_seq = s1;
                        n_ps  = p1;
                        if (r_cmd == CMD_EMPTY) begin
                            n_ep = ep_inc;
                            if (tmo_hit) begin
                                n_seq = seq_mod({1'b0, r_ack} + 9'd1);
                                n_ps  = p1 - PS_W'(win_len(s1, r_ack, 1'b1)) + 17'd1;
                                n_ep  = '0;
                            end
                        end else begin
                            n_ep = '0;
                            if ({4'b0, s1} < r_ack) begin
                                if ((r_rx <= {4'b0, s1}) || (r_rx > r_ack)) begin
                                    n_ack = r_rx;
                                end
                            end else if (r_rx > r_ack) begin
                                n_ack = r_rx;
                            end
                            if (p1 == end_ps) begin
                                res[nres[0]] = mk(K_END, '0, '0);
                                nres         = nres + 2'd1;
                                n_phase      = PH_ENDACK;
                            end
                        end
                    end
                    PH_ENDACK: begin
                        if (r_cmd == CMD_EMPTY) begin
                            n_ep = ep_inc;
                            if (tmo_hit) begin
                                n_ep   = '0;
                                res[0] = mk(K_END, '0, '0);
                                nres   = 2'd1;
                            end
                        end else if (r_rx == CODE_END) begin
                            res[0]  = mk(K_DONE, '0, '0);
                            nres    = 2'd1;
                            n_phase = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (nres == 2'd1) begin
            res[0].last = 1'b1;
        end else if (nres == 2'd2) begin
            res[1].last = 1'b1;
        end
        o_push.count = nres;
        o_push.res0  = res[0];
        o_push.res1  = res[1];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && (r_cmd == CMD_RESTART)) |=> (r_phase == PH_ANNOUNCE) && (r_ps == '0))
        else $error("restart did not clear state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq < SEQ_W'(SEQ_MODULUS))
        else $error("sequence number out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> ((o_push.res0.kind == K_DATA)
                                    && (o_push.res1.kind == K_END)))
        else $error("two results that are not data then end");

endmodule

[rtl/gbn_out_q.sv]
// small result queue that serializes up to two results per poll
module gbn_out_q
    import gbn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_CW-1:0]  r_count;
    logic             pop;
    logic [Q_AW-1:0]  wr1;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_count <= Q_CW'(Q_DEPTH - 2));
    assign wr1     = r_wr + Q_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + Q_AW'(i_push.count);
            r_rd    <= r_rd + Q_AW'(pop);
            r_count <= r_count + Q_CW'(i_push.count) - Q_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.res1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("push without room");

endmodule

[rtl/go_back_n_sender.sv]
// top level of the go-back-n sender control block
//
// i_in carries one poll per beat: cmd 0 empty poll, 1 received byte in
// rx_byte, 2 restart. o_out carries result beats (kind, seq_out,
// packet_index, last); last marks the final result of a poll. i_cfg writes
// register 0 total_packets and register 1 timeout_polls; it is always ready
// and is meant to be used while the block is idle.
// A poll is held in an input register, evaluated combinationally from there
// and its zero, one or two results are written into the result queue, from
// which the first result is taken. One poll per cycle is taken while the
// queue has room and the output drains one result per cycle; the four-entry
// result queue absorbs the extra result of a poll that yields two.
// When the receiver stalls, the queue fills and i_in.ready drops once fewer
// than two entries are free; nothing is lost.
// Synchronous reset empties the queue, returns the protocol to announce
// and restores total_packets 0 and timeout_polls 10.
module go_back_n_sender
    import gbn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gbn_in_if.sink    i_in,
    gbn_out_if.source o_out,
    gbn_cfg_if.sink   i_cfg
);

    t_push   push;
    logic    room;
    t_result res;

    assign i_cfg.ready = 1'b1;

    gbn_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_cmd       (i_in.cmd),
        .i_rx_byte   (i_in.rx_byte),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_room      (room),
        .o_push      (push)
    );

    gbn_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.kind         = 3'(res.kind);
    assign o_out.seq_out      = res.seq;
    assign o_out.packet_index = res.idx;
    assign o_out.last         = res.last;

endmodule
